### rtl/core/smac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_pkg
// Shared constants, types and functions of the softmax/argmax classifier.
// ----------------------------------------------------------------------------
package smac_pkg;

	localparam int SCORE_FIELDS = 8;
	localparam int SCORE_W      = 32;
	localparam int Q_W          = 16;
	localparam int CONF_W       = 16;
	localparam int CLASS_W      = 3;
	localparam int DEF_NUM_CLASSES = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int EXP_W        = 17;
	localparam int SUM_W        = 21;
	localparam int DIV_Q_W      = 17;

	typedef enum logic [1:0] {
		FMT_F32 = 2'd0,
		FMT_F16 = 2'd1,
		FMT_NONE2 = 2'd2,
		FMT_NONE3 = 2'd3
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT   = 1'b0,
		REG_MIN_CONF = 1'b1
	} reg_idx_t;

	function automatic logic signed [Q_W-1:0] sat_q78(input logic neg, input logic [31:0] mag);
		logic signed [Q_W-1:0] r;
		if (neg) begin
			if (mag >= 32'd32768) r = 16'sh8000;
			else r = -$signed({1'b0, mag[14:0]});
		end else begin
			if (mag > 32'd32767) r = 16'sh7fff;
			else r = $signed({1'b0, mag[14:0]});
		end
		return r;
	endfunction

	// Significand shifted by ex - bias; a shift above 8 is far outside Q7.8
	// and saturates, so the 32-bit result never wraps.
	function automatic logic [31:0] scale(input logic [23:0] sig, input int sh);
		logic [31:0] r;
		if (sh > 8) r = 32'hffff_ffff;
		else if (sh >= 0) r = {8'd0, sig} << sh;
		else if (sh <= -32) r = 32'd0;
		else r = {8'd0, sig} >> (-sh);
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] dec_f32(input logic [31:0] b);
		logic signed [Q_W-1:0] r;
		if (b[30:23] == 8'hff) r = (b[22:0] != 0) ? '0 : sat_q78(b[31], 32'hffff_ffff);
		else if (b[30:23] == 8'h00) r = '0;
		else r = sat_q78(b[31], scale({1'b1, b[22:0]}, int'(b[30:23]) - 142));
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] dec_f16(input logic [15:0] b);
		logic signed [Q_W-1:0] r;
		if (b[14:10] == 5'h1f) r = (b[9:0] != 0) ? '0 : sat_q78(b[15], 32'hffff_ffff);
		else if (b[14:10] == 5'h00) r = '0;
		else r = sat_q78(b[15], scale({13'd1, b[9:0], 1'b0} >> 1, int'(b[14:10]) - 17));
		return r;
	endfunction

	function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
		logic [EXP_W-1:0] r;
		case (n)
			4'd0: r = 17'd65536; 4'd1: r = 17'd24109; 4'd2: r = 17'd8869;
			4'd3: r = 17'd3263;  4'd4: r = 17'd1200;  4'd5: r = 17'd442;
			4'd6: r = 17'd162;   4'd7: r = 17'd60;    4'd8: r = 17'd22;
			4'd9: r = 17'd8;     4'd10: r = 17'd3;    4'd11: r = 17'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] h);
		logic [EXP_W-1:0] r;
		case (h)
			4'd0: r = 17'd65536;  4'd1: r = 17'd61565;  4'd2: r = 17'd57835;
			4'd3: r = 17'd54331;  4'd4: r = 17'd51039;  4'd5: r = 17'd47947;
			4'd6: r = 17'd45042;  4'd7: r = 17'd42313;  4'd8: r = 17'd39750;
			4'd9: r = 17'd37341;  4'd10: r = 17'd35079; 4'd11: r = 17'd32954;
			4'd12: r = 17'd30957; 4'd13: r = 17'd29081; 4'd14: r = 17'd27319;
			default: r = 17'd25664;
		endcase
		return r;
	endfunction

	function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] l);
		logic [EXP_W-1:0] r;
		case (l)
			4'd0: r = 17'd65536;  4'd1: r = 17'd65281;  4'd2: r = 17'd65026;
			4'd3: r = 17'd64772;  4'd4: r = 17'd64520;  4'd5: r = 17'd64268;
			4'd6: r = 17'd64018;  4'd7: r = 17'd63768;  4'd8: r = 17'd63520;
			4'd9: r = 17'd63272;  4'd10: r = 17'd63025; 4'd11: r = 17'd62780;
			4'd12: r = 17'd62535; 4'd13: r = 17'd62291; 4'd14: r = 17'd62048;
			default: r = 17'd61806;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/smac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_in_if / smac_out_if
// Valid/ready channels for score vectors and classification results.
// ----------------------------------------------------------------------------
interface smac_in_if;
	import smac_pkg::*;
	logic                valid;
	logic                ready;
	logic [SCORE_W-1:0]  score_0, score_1, score_2, score_3;
	logic [SCORE_W-1:0]  score_4, score_5, score_6, score_7;
	modport source (output valid, score_0, score_1, score_2, score_3,
		score_4, score_5, score_6, score_7, input ready);
	modport sink (input valid, score_0, score_1, score_2, score_3,
		score_4, score_5, score_6, score_7, output ready);
endinterface

interface smac_out_if;
	import smac_pkg::*;
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] best_class;
	logic [CONF_W-1:0]  confidence;
	modport source (output valid, best_class, confidence, input ready);
	modport sink (input valid, best_class, confidence, output ready);
endinterface

### rtl/core/smac_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_divider
// Pipelined restoring divider: (2^32 + sum/2) / sum, one quotient bit a stage.
// ----------------------------------------------------------------------------
module smac_divider
	import smac_pkg::*;
#(
	parameter int PAY_W = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [SUM_W-1:0]     sum,
	input  logic [PAY_W-1:0]     in_pay,
	output logic                 out_valid,
	output logic [DIV_Q_W-1:0]   quot,
	output logic [PAY_W-1:0]     out_pay
);
	// Quotient is below 2^17 since sum >= 65536; dividend < 2^33.
	// Shifted divisor needs SUM_W + N - 1 bits.
	localparam int N   = DIV_Q_W;
	localparam int NW  = SUM_W + N + 2;

	logic                  v_q    [N+1];
	logic [NW-1:0]         rem_q  [N+1];
	logic [SUM_W-1:0]      den_q  [N+1];
	logic [N-1:0]          quo_q  [N+1];
	logic [PAY_W-1:0]      pay_q  [N+1];

	assign v_q[0]   = in_valid;
	assign rem_q[0] = (NW'(1) << 32) + NW'(sum >> 1);
	assign den_q[0] = sum;
	assign quo_q[0] = '0;
	assign pay_q[0] = in_pay;

	for (genvar k = 0; k < N; k++) begin : g_st
		localparam int SH = N - 1 - k;
		logic [NW-1:0] dsh;
		logic          take;
		assign dsh  = NW'(den_q[k]) << SH;
		assign take = rem_q[k] >= dsh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else if (adv) v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k+1] <= take ? rem_q[k] - dsh : rem_q[k];
				den_q[k+1] <= den_q[k];
				quo_q[k+1] <= {quo_q[k][N-2:0], take};
				pay_q[k+1] <= pay_q[k];
			end
		end
	end

	assign out_valid = v_q[N];
	assign quot      = quo_q[N];
	assign out_pay   = pay_q[N];
endmodule

### rtl/core/softmax_argmax_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_argmax_classifier_unit
// Argmax and softmax confidence over one vector of class scores per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in  : valid/ready channel, score_0..score_7 raw float32 or half bits.
//   out : valid/ready channel, best_class and confidence (Q0.16).
//   cfg : cfg_we/cfg_idx/cfg_data; index 0 score_format, 1 min_confidence.
//         Write only while the pipe is empty.
// Pipeline:
//   s1 decode to Q7.8, s2 max, s3 argmax index and differences,
//   s4 partial exp product, s5 exp, s6 sum, then 17 divider stages
//   (one quotient bit each), then the clamp/output register.
// Throughput: one transfer per cycle unless stalled. The whole pipe advances together;
//   it stalls only when the output register is full and not taken, so
//   the output register's holding stage is the only buffer.
// Reset: all valid bits and the cfg registers clear; data registers are not reset.
// ----------------------------------------------------------------------------
module softmax_argmax_classifier_unit
	import smac_pkg::*;
#(
	parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	smac_in_if.sink               in_ch,
	smac_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int NC = (NUM_CLASSES < SCORE_FIELDS) ? NUM_CLASSES : SCORE_FIELDS;

	logic [1:0]        fmt_q;
	logic [CONF_W-1:0] minc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= '0;
			minc_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_FORMAT:   fmt_q  <= cfg_data[1:0];
				REG_MIN_CONF: minc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipe moves when the output register can accept.
	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	logic [SCORE_W-1:0] raw [SCORE_FIELDS];
	assign raw[0] = in_ch.score_0; assign raw[1] = in_ch.score_1;
	assign raw[2] = in_ch.score_2; assign raw[3] = in_ch.score_3;
	assign raw[4] = in_ch.score_4; assign raw[5] = in_ch.score_5;
	assign raw[6] = in_ch.score_6; assign raw[7] = in_ch.score_7;

	// s1: decode
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [Q_W-1:0] sc_s1 [NC];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NC; i++) begin
				case (fmt_t'(fmt_q))
					FMT_F32: sc_s1[i] <= dec_f32(raw[i]);
					FMT_F16: sc_s1[i] <= dec_f16(raw[i][15:0]);
					default: sc_s1[i] <= '0;
				endcase
			end
		end
	end

	// s2: max value
	logic signed [Q_W-1:0] sc_s2 [NC];
	logic signed [Q_W-1:0] mx_s2;
	logic signed [Q_W-1:0] mx_c;
	always_comb begin
		mx_c = sc_s1[0];
		for (int i = 1; i < NC; i++) if (sc_s1[i] > mx_c) mx_c = sc_s1[i];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s2 <= sc_s1;
			mx_s2 <= mx_c;
		end
	end

	// s3: lowest index equal to max, and differences
	logic [CLASS_W-1:0] best_c, best_s3, best_s4, best_s5, best_s6;
	logic [Q_W-1:0]     d_s3 [NC];
	always_comb begin
		best_c = '0;
		for (int i = NC - 1; i >= 0; i--) if (sc_s2[i] == mx_s2) best_c = CLASS_W'(i);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			best_s3 <= best_c;
			for (int i = 0; i < NC; i++) d_s3[i] <= Q_W'(mx_s2 - sc_s2[i]);
		end
	end

	// s4: fractional exp product
	logic [EXP_W-1:0] f_s4 [NC];
	logic [3:0]       n_s4 [NC];
	logic [NC-1:0]    z_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			best_s4 <= best_s3;
			for (int i = 0; i < NC; i++) begin
				f_s4[i] <= EXP_W'(({17'd0, exp_hi(d_s3[i][7:4])} * {17'd0, exp_lo(d_s3[i][3:0])}
					+ 34'd32768) >> 16);
				n_s4[i] <= d_s3[i][11:8];
				z_s4[i] <= d_s3[i][15:8] >= 8'd12;
			end
		end
	end

	// s5: integer part
	logic [EXP_W-1:0] e_s5 [NC];
	always_ff @(posedge clk) begin
		if (adv) begin
			best_s5 <= best_s4;
			for (int i = 0; i < NC; i++)
				e_s5[i] <= z_s4[i] ? '0 : EXP_W'(({17'd0, exp_int(n_s4[i])} * {17'd0, f_s4[i]}
					+ 34'd32768) >> 16);
		end
	end

	// s6: sum
	logic [SUM_W-1:0] sum_c, sum_s6;
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NC; i++) sum_c = sum_c + SUM_W'(e_s5[i]);
		if (sum_c == '0) sum_c = SUM_W'(65536);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			best_s6 <= best_s5;
			sum_s6  <= sum_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	logic                dv;
	logic [DIV_Q_W-1:0]  quot;
	logic [CLASS_W-1:0]  dbest;

	smac_divider #(.PAY_W(CLASS_W)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v_s6), .sum(sum_s6), .in_pay(best_s6),
		.out_valid(dv), .quot(quot), .out_pay(dbest)
	);

	// Output register: saturate and apply lower clamp.
	logic [CONF_W-1:0] sat_c, conf_c;
	assign sat_c  = (quot > DIV_Q_W'(65535)) ? CONF_W'(65535) : quot[CONF_W-1:0];
	assign conf_c = (sat_c < minc_q) ? minc_q : sat_c;

	logic v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (adv) v_q <= dv;
	end
	always_ff @(posedge clk) begin
		if (adv && dv) begin
			out_ch.best_class <= dbest;
			out_ch.confidence <= conf_c;
		end
	end
	assign out_ch.valid = v_q;

	// Checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.confidence))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && $rose(out_ch.valid) |-> out_ch.confidence >= minc_q)
		else $error("confidence below threshold");
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> 32'(out_ch.best_class) < NC)
		else $error("class out of range");
endmodule
